### rtl/x86ls_pkg.sv
// shared types and constants for the x86 logic and shift unit
package x86ls_pkg;

    localparam int DataWidth = 32;
    localparam int CountWidth = 5;

    typedef enum logic [3:0] {
        OP_ROL   = 4'd0,
        OP_TEST  = 4'd1,
        OP_AND   = 4'd2,
        OP_XOR   = 4'd3,
        OP_OR    = 4'd4,
        OP_SAR   = 4'd5,
        OP_SHL   = 4'd6,
        OP_SHR   = 4'd7,
        OP_SETCC = 4'd8,
        OP_NOT   = 4'd9
    } opcode_t;

    typedef enum logic [1:0] {
        SIZE_BYTE  = 2'd0,
        SIZE_WORD  = 2'd1,
        SIZE_DWORD = 2'd2
    } size_code_t;

    typedef enum logic [2:0] {
        CC_O  = 3'd0,
        CC_B  = 3'd1,
        CC_Z  = 3'd2,
        CC_BE = 3'd3,
        CC_S  = 3'd4,
        CC_P  = 3'd5,
        CC_L  = 3'd6,
        CC_LE = 3'd7
    } cond_t;

    typedef struct packed {
        logic zf;
        logic sf;
        logic cf;
        logic of;
    } flags_t;

    localparam flags_t FlagsReset = '{zf: 1'b0, sf: 1'b0, cf: 1'b0, of: 1'b0};

endpackage

### rtl/x86ls_alu.sv
// combinational execute logic for one logic or shift instruction
module x86ls_alu
    import x86ls_pkg::*;
(
    input  logic [3:0]           opcode,
    input  logic [DataWidth-1:0] dest_value,
    input  logic [DataWidth-1:0] src_value,
    input  logic [1:0]           size_code,
    input  logic [3:0]           cond_code,
    input  flags_t               flags_in,
    output logic [DataWidth-1:0] result_value,
    output logic                 write_enable,
    output flags_t               flags_out
);

    logic [DataWidth-1:0]   mask;
    logic [DataWidth-1:0]   d;
    logic [DataWidth-1:0]   s;
    logic [CountWidth-1:0]  cnt;
    logic [DataWidth-1:0]   sext;
    logic [DataWidth-1:0]   rol_val;
    logic [2*DataWidth-1:0] rot32;
    logic [31:0]            rot16;
    logic [15:0]            rot8;
    logic [DataWidth-1:0]   logic_val;
    logic [DataWidth-1:0]   r;
    logic                   zf_calc;
    logic                   sf_calc;
    logic                   cond_hit;

    always_comb begin
        case (size_code)
            SIZE_BYTE: mask = 32'h0000_00ff;
            SIZE_WORD: mask = 32'h0000_ffff;
            default:   mask = 32'hffff_ffff;
        endcase
    end

    assign d   = dest_value & mask;
    assign s   = src_value & mask;
    assign cnt = src_value[CountWidth-1:0];

    always_comb begin
        case (size_code)
            SIZE_BYTE: sext = {{24{d[7]}}, d[7:0]};
            SIZE_WORD: sext = {{16{d[15]}}, d[15:0]};
            default:   sext = d;
        endcase
    end

    // rotate by count modulo operand size
    assign rot32 = {d, d} << cnt;
    assign rot16 = {d[15:0], d[15:0]} << cnt[3:0];
    assign rot8  = {d[7:0], d[7:0]} << cnt[2:0];

    always_comb begin
        case (size_code)
            SIZE_BYTE: rol_val = {24'd0, rot8[15:8]};
            SIZE_WORD: rol_val = {16'd0, rot16[31:16]};
            default:   rol_val = rot32[2*DataWidth-1:DataWidth];
        endcase
    end

    always_comb begin
        case (opcode_t'(opcode))
            OP_XOR:  logic_val = d ^ s;
            OP_OR:   logic_val = d | s;
            default: logic_val = d & s;
        endcase
    end

    always_comb begin
        case (cond_t'(cond_code[3:1]))
            CC_O:    cond_hit = flags_in.of;
            CC_B:    cond_hit = flags_in.cf;
            CC_Z:    cond_hit = flags_in.zf;
            CC_BE:   cond_hit = flags_in.cf | flags_in.zf;
            CC_S:    cond_hit = flags_in.sf;
            CC_L:    cond_hit = flags_in.sf ^ flags_in.of;
            CC_LE:   cond_hit = flags_in.zf | (flags_in.sf ^ flags_in.of);
            default: cond_hit = 1'b0;
        endcase
        // parity is never tracked, so both senses read as false
        if (cond_t'(cond_code[3:1]) != CC_P) begin
            cond_hit = cond_hit ^ cond_code[0];
        end
    end

    always_comb begin
        r = '0;
        write_enable = 1'b1;
        case (opcode_t'(opcode))
            OP_ROL:   r = rol_val;
            OP_TEST:  write_enable = 1'b0;
            OP_AND:   r = logic_val;
            OP_XOR:   r = logic_val;
            OP_OR:    r = logic_val;
            OP_SAR:   r = DataWidth'($signed(sext) >>> cnt) & mask;
            OP_SHL:   r = (d << cnt) & mask;
            OP_SHR:   r = d >> cnt;
            OP_SETCC: r = {{(DataWidth-1){1'b0}}, cond_hit};
            OP_NOT:   r = ~d & mask;
            default:  write_enable = 1'b0;
        endcase
    end

    assign result_value = r;

    // zf and sf come from the value written, or the and value for test
    always_comb begin
        logic [DataWidth-1:0] v;
        v = (opcode_t'(opcode) == OP_TEST) ? logic_val : r;
        zf_calc = (v == '0);
        case (size_code)
            SIZE_BYTE: sf_calc = v[7];
            SIZE_WORD: sf_calc = v[15];
            default:   sf_calc = v[DataWidth-1];
        endcase
    end

    always_comb begin
        flags_out = flags_in;
        case (opcode_t'(opcode))
            OP_TEST, OP_AND, OP_XOR, OP_OR: begin
                flags_out.zf = zf_calc;
                flags_out.sf = sf_calc;
                flags_out.cf = 1'b0;
                flags_out.of = 1'b0;
            end
            OP_SHL, OP_SHR: begin
                flags_out.zf = zf_calc;
                flags_out.sf = sf_calc;
            end
            default: flags_out = flags_in;
        endcase
    end

endmodule

### rtl/x86_logic_shift_unit.sv
// top level of the x86 logic and shift unit
//
// input channel s_*: one instruction per transfer (opcode, operands, size,
// condition subcode). result channel m_*: written value, write enable and
// the four kept flags after that instruction.
// an accepted instruction is held in the input register and is
// executed into the result register when that register can advance,
// and m_valid rises as the result register is loaded.
// throughput is one instruction per cycle while m_ready is not held low;
// the kept flags are updated in the same edge that loads the result
// register, so each instruction sees the flags of the one before it.
// when the receiver holds m_ready low, the result register holds its
// value and the input register keeps one more instruction; s_ready then
// falls until the result is taken.
// synchronous active-low reset empties both registers and clears all
// kept flags.
module x86_logic_shift_unit
    import x86ls_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [3:0]           s_opcode,
    input  logic [DataWidth-1:0] s_dest_value,
    input  logic [DataWidth-1:0] s_src_value,
    input  logic [1:0]           s_size_code,
    input  logic [3:0]           s_cond_code,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [DataWidth-1:0] m_result_value,
    output logic                 m_write_enable,
    output logic                 m_zero_flag,
    output logic                 m_sign_flag,
    output logic                 m_carry_flag,
    output logic                 m_overflow_flag
);

    logic                 in_valid_reg;
    logic [3:0]           opcode_reg;
    logic [DataWidth-1:0] dest_reg;
    logic [DataWidth-1:0] src_reg;
    logic [1:0]           size_reg;
    logic [3:0]           cond_reg;
    logic                 out_valid_reg;
    logic [DataWidth-1:0] result_reg;
    logic                 we_reg;
    flags_t               flags_reg;
    flags_t               flags_next;
    logic [DataWidth-1:0] result_next;
    logic                 we_next;
    logic                 advance;

    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;

    x86ls_alu u_alu (
        .opcode       (opcode_reg),
        .dest_value   (dest_reg),
        .src_value    (src_reg),
        .size_code    (size_reg),
        .cond_code    (cond_reg),
        .flags_in     (flags_reg),
        .result_value (result_next),
        .write_enable (we_next),
        .flags_out    (flags_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            opcode_reg <= s_opcode;
            dest_reg   <= s_dest_value;
            src_reg    <= s_src_value;
            size_reg   <= s_size_code;
            cond_reg   <= s_cond_code;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            flags_reg     <= FlagsReset;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg) begin
                flags_reg <= flags_next;
            end
        end
        if (advance && in_valid_reg) begin
            result_reg <= result_next;
            we_reg     <= we_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_result_value  = result_reg;
    assign m_write_enable  = we_reg;
    assign m_zero_flag     = flags_reg.zf;
    assign m_sign_flag     = flags_reg.sf;
    assign m_carry_flag    = flags_reg.cf;
    assign m_overflow_flag = flags_reg.of;

endmodule

### rtl/x86ls_checker.sv
// port-level checks for the x86 logic and shift unit, bound to the top level
module x86ls_checker
    import x86ls_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [DataWidth-1:0] m_result_value,
    input logic                 m_write_enable,
    input logic                 m_zero_flag,
    input logic                 m_sign_flag,
    input logic                 m_carry_flag,
    input logic                 m_overflow_flag
);

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_value)
            && $stable(m_write_enable) && $stable(m_zero_flag)
            && $stable(m_sign_flag) && $stable(m_carry_flag)
            && $stable(m_overflow_flag))
        else $error("stalled result changed");

    a_no_write_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_write_enable |-> m_result_value == '0)
        else $error("non-writing instruction returned a value");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

endmodule

bind x86_logic_shift_unit x86ls_checker u_x86ls_checker (.*);
